/* design/first_fit_extent_allocator_macros.svh */
// assertion helpers for the extent allocator
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FFEA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FFEA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/ffea_pkg.sv */
`timescale 1ns / 1ps
package ffea_pkg;
  localparam int unsigned MaxExtentsDef = 64;
  localparam int unsigned BlockRowsDef  = 4;
  localparam int unsigned RowBytesDef   = 12;
  localparam int unsigned NumClasses    = 4;
  localparam int unsigned MaskW         = 7;
  localparam int unsigned BlocksW       = 19;
  localparam logic [MaskW-1:0] MaskCap  = 7'd64;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoClass = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_CUBE, S_CAP, S_SCAN, S_SHL,
    S_FSCAN, S_FDEC, S_SHR, S_FWR, S_DONE
  } state_e;

  typedef struct packed {
    logic        we;
    logic [31:0] wstart;
    logic [31:0] wlen;
  } mem_wr_t;
endpackage

/* design/ffea_ram.sv */
`timescale 1ns / 1ps
module ffea_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/first_fit_extent_allocator.sv */
`timescale 1ns / 1ps
// channel  | dir | content
// s_axis   | in  | tdata: op, request_bytes, free_start, free_count
// m_axis   | out | tdata: status, chosen_mask, alloc_start, alloc_blocks
// cfg      | in  | write enable, register index, 7-bit data
// alloc: each size class tried passes the class, cube and capacity states; the
// table is then scanned entry by entry, entries are moved down when an extent is
// used up, and the result is posted; free: a scan of the entries below its start,
// a decision, entries moved, the merged extent written, and the result posted.
// reset empties the table (used count zero) and clears the tail, no clearing pass
// input is ready only in idle; a finished result waits while the result beat is held
module first_fit_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = ffea_pkg::MaxExtentsDef,
  parameter int unsigned BLOCK_ROWS  = ffea_pkg::BlockRowsDef,
  parameter int unsigned ROW_BYTES   = ffea_pkg::RowBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata, // op, request_bytes, free_start, free_count
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata, // status, chosen_mask, alloc_start, alloc_blocks
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [6:0]   cfg_data_i
);
  import ffea_pkg::*;

  localparam int unsigned AW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [31:0] CapK = 32'(BLOCK_ROWS * ROW_BYTES);
  localparam logic [CW-1:0] MaxUsed = CW'(MAX_EXTENTS);

  state_e state_q, state_d;
  logic [MaskW-1:0] mask_q [NumClasses];
  logic [CW-1:0] used_q, idx_q, dst_q, nused_q, p_q, ins_q, r_q;
  logic [31:0] tail_q, req_q, fs_q, fc_q;
  logic [1:0] k_q;
  logic [MaskW-1:0] m_q;
  logic [13:0] sq_q;
  logic [BlocksW-1:0] blk_q;
  logic [31:0] pst_q, plen_q, eps_q, epl_q;
  logic hasprev_q, same_q;
  logic [31:0] nst_q, nlen_q;
  logic [1:0] st_q;
  logic [MaskW-1:0] wmask_q;
  logic [31:0] wstart_q;
  logic [BlocksW-1:0] wblk_q;
  logic ovalid_q;
  logic [1:0] ost_q;
  logic [MaskW-1:0] omask_q;
  logic [31:0] ostart_q;
  logic [BlocksW-1:0] oblk_q;

  logic [31:0] rs, rl;
  mem_wr_t wr;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] mc_a, mc_b;
  logic [63:0] mc_p;
  logic [MaskW-1:0] mcl;
  logic fits, alloc_hit;
  logic mprev, mnext, grow, hasq;
  logic [31:0] qs, ql;
  logic [32:0] fend;
  logic [33:0] nlen_sum;
  logic [CW-1:0] ins_c, r_c, nused_c;

  ffea_ram #(.Width(32), .Depth(MAX_EXTENTS)) u_start (
    .clk_i, .we_i(wr.we), .waddr_i(waddr), .wdata_i(wr.wstart), .raddr_i(raddr),
    .rdata_o(rs));
  ffea_ram #(.Width(32), .Depth(MAX_EXTENTS)) u_len (
    .clk_i, .we_i(wr.we), .waddr_i(waddr), .wdata_i(wr.wlen), .raddr_i(raddr),
    .rdata_o(rl));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'd0, oblk_q, ostart_q, omask_q, ost_q};

  // one shared multiplier for square, cube and byte capacity
  always_comb begin
    mcl = (mask_q[k_q] > MaskCap) ? MaskCap : mask_q[k_q];
    mc_a = 32'(mcl);
    mc_b = 32'(mcl);
    if (state_q == S_CUBE) begin
      mc_a = 32'(m_q);
      mc_b = 32'(sq_q);
    end else if (state_q == S_CAP) begin
      mc_a = 32'(blk_q);
      mc_b = CapK;
    end
  end
  assign mc_p = 64'(mc_a) * 64'(mc_b);
  assign fits = 64'(req_q) <= mc_p;
  assign alloc_hit = (idx_q < used_q) && (rl >= 32'(blk_q));

  // free decision; rs/rl hold the entry after p when p matched the start
  always_comb begin
    fend = 33'(fs_q) + 33'(fc_q);
    mprev = hasprev_q && (33'(pst_q) + 33'(plen_q) == 33'(fs_q));
    if (same_q) begin
      hasq = (p_q + CW'(1)) < used_q;
      qs = rs;
      ql = rl;
    end else begin
      hasq = p_q < used_q;
      qs = eps_q;
      ql = epl_q;
    end
    mnext = hasq && (33'(qs) == fend);
    grow = !(mprev || mnext || same_q);
    ins_c = mprev ? p_q - CW'(1) : p_q;
    r_c = p_q + CW'(same_q) + CW'(mnext);
    nused_c = ins_c + CW'(1) + used_q - r_c;
    nlen_sum = 34'(fc_q) + (mprev ? 34'(plen_q) : 34'd0) + (mnext ? 34'(ql) : 34'd0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) begin
        if (s_axis_tdata[0] == OpAlloc) state_d = S_CLASS;
        else if (s_axis_tdata[96:65] == 32'd0) state_d = S_DONE;
        else state_d = S_FSCAN;
      end
      S_CLASS: state_d = S_CUBE;
      S_CUBE: state_d = S_CAP;
      S_CAP: begin
        if (fits) state_d = S_SCAN;
        else if (k_q == 2'(NumClasses - 1)) state_d = S_DONE;
        else state_d = S_CLASS;
      end
      S_SCAN: begin
        if (idx_q >= used_q) state_d = S_DONE;
        else if (alloc_hit) state_d = (rl == 32'(blk_q)) ? S_SHL : S_DONE;
      end
      S_SHL: if (idx_q >= used_q) state_d = S_DONE;
      S_FSCAN: if (!(idx_q < used_q && rs < fs_q)) state_d = S_FDEC;
      S_FDEC: begin
        if (grow && used_q >= MaxUsed) state_d = S_DONE;
        else if (grow) state_d = S_SHR;
        else state_d = S_FWR;
      end
      S_SHR: if (idx_q <= p_q) state_d = S_FWR;
      S_FWR: state_d = (r_q > ins_q + CW'(1) && r_q < used_q) ? S_SHL : S_DONE;
      S_DONE: if (!ovalid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ram read is registered, so each state addresses what the next one needs
  always_comb begin
    raddr = idx_q[AW-1:0];
    waddr = idx_q[AW-1:0];
    wr = '0;
    unique case (state_q)
      S_IDLE: raddr = '0;
      S_SCAN: begin
        raddr = AW'(idx_q + CW'(1));
        if (alloc_hit && rl != 32'(blk_q)) begin
          wr.we = 1'b1;
          wr.wstart = rs + 32'(blk_q);
          wr.wlen = rl - 32'(blk_q);
        end
      end
      S_SHL: begin
        raddr = AW'(idx_q + CW'(1));
        waddr = dst_q[AW-1:0];
        if (idx_q < used_q) begin
          wr.we = 1'b1; wr.wstart = rs; wr.wlen = rl;
        end
      end
      S_FSCAN: raddr = AW'(idx_q + CW'(1));
      S_FDEC: raddr = AW'(used_q - CW'(1));
      S_SHR: begin
        raddr = AW'(idx_q - CW'(2));
        if (idx_q > p_q) begin
          wr.we = 1'b1; wr.wstart = rs; wr.wlen = rl;
        end
      end
      S_FWR: begin
        raddr = r_q[AW-1:0];
        waddr = ins_q[AW-1:0];
        wr.we = 1'b1; wr.wstart = nst_q; wr.wlen = nlen_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q[0] <= 7'd1; mask_q[1] <= 7'd2; mask_q[2] <= 7'd4; mask_q[3] <= 7'd8;
      used_q <= '0; tail_q <= '0; ovalid_q <= 1'b0; idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mask_q[cfg_idx_i] <= cfg_data_i;
      if (state_q == S_DONE && state_d == S_IDLE) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          req_q <= s_axis_tdata[32:1];
          fs_q <= s_axis_tdata[64:33]; fc_q <= s_axis_tdata[96:65];
          k_q <= '0; idx_q <= '0; st_q <= StOk; wmask_q <= '0; wstart_q <= '0;
          wblk_q <= '0; hasprev_q <= 1'b0;
        end
        S_CLASS: begin m_q <= mcl; sq_q <= mc_p[13:0]; end
        S_CUBE: blk_q <= mc_p[BlocksW-1:0];
        S_CAP: begin
          if (fits) begin
            wmask_q <= m_q; wblk_q <= blk_q;
          end else if (k_q == 2'(NumClasses - 1)) begin
            st_q <= StNoClass;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_SCAN: begin
          if (idx_q >= used_q) begin
            wstart_q <= tail_q; tail_q <= tail_q + 32'(blk_q);
          end else if (alloc_hit) begin
            wstart_q <= rs;
            // extent used up: close the gap
            if (rl == 32'(blk_q)) begin
              idx_q <= idx_q + CW'(1); dst_q <= idx_q; nused_q <= used_q - CW'(1);
            end
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_SHL: begin
          if (idx_q < used_q) begin
            idx_q <= idx_q + CW'(1); dst_q <= dst_q + CW'(1);
          end else begin
            used_q <= nused_q;
          end
        end
        S_FSCAN: begin
          if (idx_q < used_q && rs < fs_q) begin
            hasprev_q <= 1'b1; pst_q <= rs; plen_q <= rl; idx_q <= idx_q + CW'(1);
          end else begin
            p_q <= idx_q; same_q <= (idx_q < used_q) && (rs == fs_q);
            eps_q <= rs; epl_q <= rl;
          end
        end
        S_FDEC: begin
          if (grow && used_q >= MaxUsed) begin
            st_q <= StFull;
          end else begin
            ins_q <= ins_c; r_q <= r_c; nused_q <= nused_c;
            nst_q <= mprev ? pst_q : fs_q;
            nlen_q <= (|nlen_sum[33:32]) ? 32'hFFFF_FFFF : nlen_sum[31:0];
            idx_q <= used_q;
          end
        end
        S_SHR: if (idx_q > p_q) idx_q <= idx_q - CW'(1);
        S_FWR: begin
          if (state_d == S_SHL) begin
            idx_q <= r_q; dst_q <= ins_q + CW'(1);
          end else begin
            used_q <= nused_q;
          end
        end
        S_DONE: if (state_d == S_IDLE) begin
          ost_q <= st_q; omask_q <= wmask_q; ostart_q <= wstart_q; oblk_q <= wblk_q;
        end
        default: ;
      endcase
    end
  end

  `include "first_fit_extent_allocator_macros.svh"
  `FFEA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `FFEA_ASSERT_IMP(a_used_max, clk_i, rst_ni, 1'b1, used_q <= MaxUsed)
  `FFEA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
